>>> design/sbi_pkg.sv
`timescale 1ns / 1ps
// Shared types and helpers for the segment versus box intersection test.
// No dependencies; imported by sbi_cross and the top level.
package sbi_pkg;

  // Strict sign of a value: pos and neg both low means zero.
  typedef struct packed {
    logic pos;
    logic neg;
  } sbi_sign_t;

  // True when both signs are nonzero and equal.
  function automatic logic sbi_same_side(sbi_sign_t a, sbi_sign_t b);
    return (a.pos & b.pos) | (a.neg & b.neg);
  endfunction

endpackage

>>> design/sbi_in_if.sv
`timescale 1ns / 1ps
// Valid/ready channel carrying one segment and one box per transaction.
// Standalone interface; used by the top level.
interface sbi_in_if #(
  parameter int COORD_BITS = 16
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] seg_start_x;
  logic signed [COORD_BITS-1:0] seg_start_y;
  logic signed [COORD_BITS-1:0] seg_end_x;
  logic signed [COORD_BITS-1:0] seg_end_y;
  logic signed [COORD_BITS-1:0] box_center_x;
  logic signed [COORD_BITS-1:0] box_center_y;
  logic        [COORD_BITS-1:0] box_width;
  logic        [COORD_BITS-1:0] box_height;

  modport source (
    output valid, seg_start_x, seg_start_y, seg_end_x, seg_end_y,
           box_center_x, box_center_y, box_width, box_height,
    input  ready
  );
  modport sink (
    input  valid, seg_start_x, seg_start_y, seg_end_x, seg_end_y,
           box_center_x, box_center_y, box_width, box_height,
    output ready
  );
endinterface

// Valid/ready channel carrying the hit flag of one query.
interface sbi_out_if;
  logic valid;
  logic ready;
  logic hit;

  modport source (output valid, hit, input ready);
  modport sink (input valid, hit, output ready);
endinterface

>>> design/sbi_cross.sv
`timescale 1ns / 1ps
// Exact sign of the 2-D cross product dx*ey - dy*ex, two register stages.
// Depends on sbi_pkg.
module sbi_cross #(
  parameter int DW = 18,
  parameter int EW = 19
) (
  input  logic                    clk,
  input  logic                    en,
  input  logic signed [DW-1:0]    dx,
  input  logic signed [DW-1:0]    dy,
  input  logic signed [EW-1:0]    ex,
  input  logic signed [EW-1:0]    ey,
  output sbi_pkg::sbi_sign_t      sign_r
);
  import sbi_pkg::*;

  localparam int PW = DW + EW;

  logic signed [PW-1:0] p_nxt, q_nxt, p_r, q_r;
  logic        [PW:0]   diff;
  sbi_sign_t            sign_nxt;

  assign p_nxt = dx * ey;
  assign q_nxt = dy * ex;

  // one extra bit keeps the difference exact
  assign diff         = {p_r[PW-1], p_r} - {q_r[PW-1], q_r};
  assign sign_nxt.neg = diff[PW];
  assign sign_nxt.pos = !diff[PW] && (|diff);

  always_ff @(posedge clk) begin
    if (en) begin
      p_r    <= p_nxt;
      q_r    <= q_nxt;
      sign_r <= sign_nxt;
    end
  end

endmodule

>>> design/segment_box_intersection_test.sv
`timescale 1ns / 1ps
// Segment versus axis-aligned box hit test. Each transaction on in_ch carries a segment
// and a box (center, full width, full height); out_ch returns one hit bit per transaction,
// in order. Edges and corners count as inside, and touching or collinear cases are hits.
// The block is a five-stage pipeline: it accepts one transaction every cycle while out_ch
// is not stalled. The only throttle is the output: while a result waits on out_ch,
// the whole pipeline holds and in_ch.ready drops. Depends on sbi_pkg, sbi_in_if/sbi_out_if
// and sbi_cross.
module segment_box_intersection_test #(
  parameter int COORD_BITS = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  sbi_in_if.sink    in_ch,
  sbi_out_if.source out_ch
);
  import sbi_pkg::*;

  localparam int N  = COORD_BITS;
  localparam int PB = N + 1;   // doubled point
  localparam int EB = N + 2;   // box edge, segment delta
  localparam int DB = N + 3;   // corner minus start point

  logic adv;
  logic v1_r, v2_r, v3_r, v4_r, v5_r;

  assign adv         = !v5_r || out_ch.ready;
  assign in_ch.ready = adv;

  // stage 1: doubled coordinates, box edges, segment delta
  logic signed [PB-1:0] x1_nxt, y1_nxt, x2_nxt, y2_nxt, cx_nxt, cy_nxt;
  logic signed [PB-1:0] x1_r, y1_r, x2_r, y2_r;
  logic signed [EB-1:0] l_nxt, r_nxt, t_nxt, b_nxt, dx_nxt, dy_nxt;
  logic signed [EB-1:0] l_r, r_r, t_r, b_r, dx1_r, dy1_r;
  logic                 wnz1_r, hnz1_r;

  assign x1_nxt = $signed({in_ch.seg_start_x, 1'b0});
  assign y1_nxt = $signed({in_ch.seg_start_y, 1'b0});
  assign x2_nxt = $signed({in_ch.seg_end_x, 1'b0});
  assign y2_nxt = $signed({in_ch.seg_end_y, 1'b0});
  assign cx_nxt = $signed({in_ch.box_center_x, 1'b0});
  assign cy_nxt = $signed({in_ch.box_center_y, 1'b0});

  assign l_nxt  = $signed({cx_nxt[PB-1], cx_nxt}) - $signed({2'b00, in_ch.box_width});
  assign r_nxt  = $signed({cx_nxt[PB-1], cx_nxt}) + $signed({2'b00, in_ch.box_width});
  assign t_nxt  = $signed({cy_nxt[PB-1], cy_nxt}) - $signed({2'b00, in_ch.box_height});
  assign b_nxt  = $signed({cy_nxt[PB-1], cy_nxt}) + $signed({2'b00, in_ch.box_height});
  assign dx_nxt = $signed({x2_nxt[PB-1], x2_nxt}) - $signed({x1_nxt[PB-1], x1_nxt});
  assign dy_nxt = $signed({y2_nxt[PB-1], y2_nxt}) - $signed({y1_nxt[PB-1], y1_nxt});

  always_ff @(posedge clk) begin
    if (adv) begin
      x1_r   <= x1_nxt;
      y1_r   <= y1_nxt;
      x2_r   <= x2_nxt;
      y2_r   <= y2_nxt;
      l_r    <= l_nxt;
      r_r    <= r_nxt;
      t_r    <= t_nxt;
      b_r    <= b_nxt;
      dx1_r  <= dx_nxt;
      dy1_r  <= dy_nxt;
      wnz1_r <= |in_ch.box_width;
      hnz1_r <= |in_ch.box_height;
    end
  end

  // stage 2: corner offsets from the start point, endpoint versus edge signs
  logic signed [EB-1:0] px1, py1, px2, py2;
  logic signed [DB-1:0] exl_nxt, exr_nxt, eyt_nxt, eyb_nxt;
  logic signed [DB-1:0] exl_r, exr_r, eyt_r, eyb_r;
  logic signed [EB-1:0] dx2_r, dy2_r;
  logic                 wnz2_r, hnz2_r;
  sbi_sign_t            x1l_nxt, x1r_nxt, x2l_nxt, x2r_nxt;
  sbi_sign_t            y1t_nxt, y1b_nxt, y2t_nxt, y2b_nxt;
  sbi_sign_t            x1l_2_r, x1r_2_r, x2l_2_r, x2r_2_r;
  sbi_sign_t            y1t_2_r, y1b_2_r, y2t_2_r, y2b_2_r;

  assign px1 = $signed({x1_r[PB-1], x1_r});
  assign py1 = $signed({y1_r[PB-1], y1_r});
  assign px2 = $signed({x2_r[PB-1], x2_r});
  assign py2 = $signed({y2_r[PB-1], y2_r});

  assign exl_nxt = $signed({l_r[EB-1], l_r}) - $signed({px1[EB-1], px1});
  assign exr_nxt = $signed({r_r[EB-1], r_r}) - $signed({px1[EB-1], px1});
  assign eyt_nxt = $signed({t_r[EB-1], t_r}) - $signed({py1[EB-1], py1});
  assign eyb_nxt = $signed({b_r[EB-1], b_r}) - $signed({py1[EB-1], py1});

  assign x1l_nxt = '{pos: px1 > l_r, neg: px1 < l_r};
  assign x1r_nxt = '{pos: px1 > r_r, neg: px1 < r_r};
  assign x2l_nxt = '{pos: px2 > l_r, neg: px2 < l_r};
  assign x2r_nxt = '{pos: px2 > r_r, neg: px2 < r_r};
  assign y1t_nxt = '{pos: py1 > t_r, neg: py1 < t_r};
  assign y1b_nxt = '{pos: py1 > b_r, neg: py1 < b_r};
  assign y2t_nxt = '{pos: py2 > t_r, neg: py2 < t_r};
  assign y2b_nxt = '{pos: py2 > b_r, neg: py2 < b_r};

  always_ff @(posedge clk) begin
    if (adv) begin
      exl_r   <= exl_nxt;
      exr_r   <= exr_nxt;
      eyt_r   <= eyt_nxt;
      eyb_r   <= eyb_nxt;
      dx2_r   <= dx1_r;
      dy2_r   <= dy1_r;
      wnz2_r  <= wnz1_r;
      hnz2_r  <= hnz1_r;
      x1l_2_r <= x1l_nxt;
      x1r_2_r <= x1r_nxt;
      x2l_2_r <= x2l_nxt;
      x2r_2_r <= x2r_nxt;
      y1t_2_r <= y1t_nxt;
      y1b_2_r <= y1b_nxt;
      y2t_2_r <= y2t_nxt;
      y2b_2_r <= y2b_nxt;
    end
  end

  // stages 3 and 4: side of each box corner relative to the segment line
  sbi_sign_t tl_r, tr_r, br_r, bl_r;

  sbi_cross #(.DW(EB), .EW(DB)) u_cross_tl (
    .clk(clk), .en(adv), .dx(dx2_r), .dy(dy2_r), .ex(exl_r), .ey(eyt_r), .sign_r(tl_r)
  );
  sbi_cross #(.DW(EB), .EW(DB)) u_cross_tr (
    .clk(clk), .en(adv), .dx(dx2_r), .dy(dy2_r), .ex(exr_r), .ey(eyt_r), .sign_r(tr_r)
  );
  sbi_cross #(.DW(EB), .EW(DB)) u_cross_br (
    .clk(clk), .en(adv), .dx(dx2_r), .dy(dy2_r), .ex(exr_r), .ey(eyb_r), .sign_r(br_r)
  );
  sbi_cross #(.DW(EB), .EW(DB)) u_cross_bl (
    .clk(clk), .en(adv), .dx(dx2_r), .dy(dy2_r), .ex(exl_r), .ey(eyb_r), .sign_r(bl_r)
  );

  // carry endpoint/edge information alongside the cross product stages
  logic in1_3_r, in2_3_r, in1_4_r, in2_4_r;
  logic rej_t_3_r, rej_r_3_r, rej_b_3_r, rej_l_3_r;
  logic rej_t_4_r, rej_r_4_r, rej_b_4_r, rej_l_4_r;
  logic in1_nxt, in2_nxt;

  assign in1_nxt = !x1l_2_r.neg && !x1r_2_r.pos && !y1t_2_r.neg && !y1b_2_r.pos;
  assign in2_nxt = !x2l_2_r.neg && !x2r_2_r.pos && !y2t_2_r.neg && !y2b_2_r.pos;

  always_ff @(posedge clk) begin
    if (adv) begin
      in1_3_r   <= in1_nxt;
      in2_3_r   <= in2_nxt;
      // both endpoints strictly on one side of an edge line; a zero-length edge never rejects
      rej_t_3_r <= wnz2_r && sbi_same_side(y1t_2_r, y2t_2_r);
      rej_r_3_r <= hnz2_r && sbi_same_side(x1r_2_r, x2r_2_r);
      rej_b_3_r <= wnz2_r && sbi_same_side(y1b_2_r, y2b_2_r);
      rej_l_3_r <= hnz2_r && sbi_same_side(x1l_2_r, x2l_2_r);
      in1_4_r   <= in1_3_r;
      in2_4_r   <= in2_3_r;
      rej_t_4_r <= rej_t_3_r;
      rej_r_4_r <= rej_r_3_r;
      rej_b_4_r <= rej_b_3_r;
      rej_l_4_r <= rej_l_3_r;
    end
  end

  // stage 5: combine into the result register
  logic meet_t, meet_r, meet_b, meet_l, hit_nxt, hit_r;

  assign meet_t  = !sbi_same_side(tl_r, tr_r) && !rej_t_4_r;
  assign meet_r  = !sbi_same_side(tr_r, br_r) && !rej_r_4_r;
  assign meet_b  = !sbi_same_side(br_r, bl_r) && !rej_b_4_r;
  assign meet_l  = !sbi_same_side(bl_r, tl_r) && !rej_l_4_r;
  assign hit_nxt = in1_4_r || in2_4_r || meet_t || meet_r || meet_b || meet_l;

  always_ff @(posedge clk) begin
    if (adv) begin
      hit_r <= hit_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_ch.valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
    end
  end

  assign out_ch.valid = v5_r;
  assign out_ch.hit   = hit_r;

  a_enter_stage1: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> v1_r)
    else $error("accepted transaction did not enter stage 1");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> ($stable(v2_r) && $stable(v3_r) && $stable(v4_r) && $stable(hit_r)))
    else $error("pipeline moved while output stalled");

  a_inside_hits: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && v4_r && (in1_4_r || in2_4_r)) |=> (v5_r && hit_r))
    else $error("endpoint inside box but no hit reported");

  a_reset_empty: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_ch.valid)
    else $error("result valid right after reset");

endmodule
